### rtl/hcbp_pkg.sv
// hcbp_pkg: shared types and constants for the code bit packer
// no dependencies; imported by huffman_code_bit_packer_core
`timescale 1ns / 1ps

package hcbp_pkg;

  localparam int unsigned WORD_BITS = 16;
  localparam int unsigned BYTE_BITS = 8;
  localparam int unsigned LEN_W     = 5;
  localparam int unsigned PEND_W    = 7;
  localparam int unsigned CNT_W     = 3;
  localparam int unsigned ACC_W     = PEND_W + WORD_BITS;

  typedef enum logic [0:0] {
    KIND_LOAD   = 1'b0,
    KIND_ENCODE = 1'b1
  } kind_e;

  typedef struct packed {
    logic [WORD_BITS-1:0] code;
    logic [LEN_W-1:0]     len;
  } code_entry_t;

  localparam int unsigned ENTRY_W = $bits(code_entry_t);

  function automatic logic [WORD_BITS-1:0] low_mask16(input logic [LEN_W-1:0] n);
    logic [WORD_BITS:0] m;
    m = ((WORD_BITS+1)'(1) << n) - (WORD_BITS+1)'(1);
    return m[WORD_BITS-1:0];
  endfunction

  function automatic logic [PEND_W-1:0] low_mask7(input logic [CNT_W-1:0] n);
    logic [PEND_W:0] m;
    m = ((PEND_W+1)'(1) << n) - (PEND_W+1)'(1);
    return m[PEND_W-1:0];
  endfunction

endpackage

### rtl/hcbp_ram.sv
// hcbp_ram: generic single-write, single-read ram with registered read
// no dependencies; holds the code table of the packer
`timescale 1ns / 1ps

module hcbp_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

### rtl/huffman_code_bit_packer_core.sv
// huffman_code_bit_packer_core: variable-length code packer top level
// depends on hcbp_pkg and hcbp_ram (code table)
`timescale 1ns / 1ps

// usage:
//   input stream carries load and encode items; tuser selects the kind
//   (0 load, 1 encode). a load writes code word and length into the code
//   table and gives no output. an encode looks up its code, appends the bits
//   to the pending bit buffer and emits every complete byte, earliest bit in
//   bit seven, on the output stream; tlast marks the last byte of a symbol.
//   fewer than eight leftover bits stay pending and are never flushed.
//   an accepted transfer reads the code table into the ram's read register,
//   is packed from there into the two-byte output buffer and offers its
//   first byte from that buffer. throughput: one item per cycle when items
//   give at most one byte and the receiver does not stall; an item giving
//   two bytes holds the output port for both, and the next item that gives bytes waits.
//   when the receiver stalls, the output buffer fills, the packing stage
//   holds and tready drops; nothing is lost. reset empties the pipeline and
//   clears the pending bits; the code table is undefined until loaded.
module huffman_code_bit_packer_core
  import hcbp_pkg::*;
#(
  parameter int unsigned MAX_CODE_LEN  = 16,
  parameter int unsigned ALPHABET_SIZE = 256
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  input  logic [31:0] s_axis_tdata_i,  // symbol[7:0], code_word[23:8], code_length[28:24]
  input  logic [0:0]  s_axis_tuser_i,  // kind[0]
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  output logic [7:0]  m_axis_tdata_o,  // out_byte[7:0]
  output logic        m_axis_tlast_o
);

  localparam int unsigned AW = $clog2(ALPHABET_SIZE);

  logic [7:0]           in_sym;
  logic [WORD_BITS-1:0] in_word;
  logic [LEN_W-1:0]     in_len;
  logic                 in_alpha;
  logic                 in_len_ok;
  logic                 accept;
  logic                 tbl_we;
  code_entry_t          tbl_wdata;
  code_entry_t          tbl_rdata;

  logic s2_valid_q, s2_valid_d;
  logic s2_fire;

  logic [PEND_W-1:0] pend_bits_q, pend_bits_d;
  logic [CNT_W-1:0]  pend_cnt_q, pend_cnt_d;

  logic [LEN_W-1:0]     e_len;
  logic [WORD_BITS-1:0] e_word;
  logic [ACC_W-1:0]     acc;
  logic [LEN_W-1:0]     cnt_sum;
  logic [LEN_W-1:0]     cnt_left;
  logic [1:0]           nb;
  logic [ACC_W-1:0]     sh_a;
  logic [ACC_W-1:0]     sh_b;
  logic [7:0]           byte_a;
  logic [7:0]           byte_b;

  logic [7:0] ob_byte_q [2];
  logic [7:0] ob_byte_d [2];
  logic       ob_last_q [2];
  logic       ob_last_d [2];
  logic [1:0] ob_cnt_q, ob_cnt_d;
  logic       pop;
  logic       free_next;

  assign in_sym  = s_axis_tdata_i[7:0];
  assign in_word = s_axis_tdata_i[23:8];
  assign in_len  = s_axis_tdata_i[28:24];

  assign in_alpha  = ({1'b0, in_sym} < 9'(ALPHABET_SIZE));
  assign in_len_ok = (in_len != '0) && ({1'b0, in_len} <= 6'(MAX_CODE_LEN))
                     && (in_len <= LEN_W'(WORD_BITS));

  assign accept = s_axis_tvalid_i && s_axis_tready_o;
  assign tbl_we = accept && (s_axis_tuser_i == KIND_LOAD) && in_alpha && in_len_ok;

  assign tbl_wdata.code = in_word & low_mask16(in_len);
  assign tbl_wdata.len  = in_len;

  hcbp_ram #(
    .WIDTH(ENTRY_W),
    .DEPTH(ALPHABET_SIZE)
  ) u_code_table (
    .clk_i  (clk_i),
    .we_i   (tbl_we),
    .waddr_i(in_sym[AW-1:0]),
    .wdata_i(tbl_wdata),
    .re_i   (accept),
    .raddr_i(in_sym[AW-1:0]),
    .rdata_o(tbl_rdata)
  );

  // packing stage
  always_comb begin
    e_len    = (tbl_rdata.len > LEN_W'(WORD_BITS)) ? '0 : tbl_rdata.len;
    e_word   = tbl_rdata.code & low_mask16(e_len);
    acc      = (ACC_W'(pend_bits_q) << e_len) | ACC_W'(e_word);
    cnt_sum  = LEN_W'(pend_cnt_q) + e_len;
    if (cnt_sum >= LEN_W'(2 * BYTE_BITS)) begin
      nb = 2'd2;
    end else if (cnt_sum >= LEN_W'(BYTE_BITS)) begin
      nb = 2'd1;
    end else begin
      nb = 2'd0;
    end
    sh_a     = acc >> (cnt_sum - LEN_W'(BYTE_BITS));
    sh_b     = acc >> (cnt_sum - LEN_W'(2 * BYTE_BITS));
    byte_a   = sh_a[7:0];
    byte_b   = sh_b[7:0];
    cnt_left = cnt_sum - LEN_W'({nb, 3'b000});
  end

  assign pop       = m_axis_tvalid_o && m_axis_tready_i;
  assign free_next = (ob_cnt_q == 2'd0) || ((ob_cnt_q == 2'd1) && pop);
  assign s2_fire   = s2_valid_q && ((nb == 2'd0) || free_next);
  assign s_axis_tready_o = !s2_valid_q || s2_fire;

  always_comb begin
    if (accept) begin
      s2_valid_d = (s_axis_tuser_i == KIND_ENCODE) && in_alpha;
    end else if (s2_fire) begin
      s2_valid_d = 1'b0;
    end else begin
      s2_valid_d = s2_valid_q;
    end
  end

  always_comb begin
    pend_bits_d = pend_bits_q;
    pend_cnt_d  = pend_cnt_q;
    if (s2_fire) begin
      pend_cnt_d  = cnt_left[CNT_W-1:0];
      pend_bits_d = acc[PEND_W-1:0] & low_mask7(cnt_left[CNT_W-1:0]);
    end
  end

  // two-entry output buffer, head in entry 0
  always_comb begin
    ob_byte_d = ob_byte_q;
    ob_last_d = ob_last_q;
    ob_cnt_d  = ob_cnt_q;
    if (s2_fire && (nb != 2'd0)) begin
      ob_cnt_d     = nb;
      ob_byte_d[0] = byte_a;
      ob_last_d[0] = (nb == 2'd1);
      ob_byte_d[1] = byte_b;
      ob_last_d[1] = 1'b1;
    end else if (pop) begin
      ob_cnt_d     = ob_cnt_q - 2'd1;
      ob_byte_d[0] = ob_byte_q[1];
      ob_last_d[0] = ob_last_q[1];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s2_valid_q  <= 1'b0;
      pend_bits_q <= '0;
      pend_cnt_q  <= '0;
      ob_cnt_q    <= '0;
    end else begin
      s2_valid_q  <= s2_valid_d;
      pend_bits_q <= pend_bits_d;
      pend_cnt_q  <= pend_cnt_d;
      ob_cnt_q    <= ob_cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    ob_byte_q <= ob_byte_d;
    ob_last_q <= ob_last_d;
  end

  assign m_axis_tvalid_o = (ob_cnt_q != 2'd0);
  assign m_axis_tdata_o  = ob_byte_q[0];
  assign m_axis_tlast_o  = ob_last_q[0];

  a_cnt_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ob_cnt_q != 2'd3)
    else $error("output buffer count out of range");

  a_pair_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (ob_cnt_q == 2'd2) |-> (!ob_last_q[0] && ob_last_q[1]))
    else $error("two buffered bytes with wrong last marks");

  a_stall_src: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !s_axis_tready_o |-> s2_valid_q)
    else $error("input stalled with empty packing stage");

  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s2_fire && (nb != 2'd0)) |-> free_next)
    else $error("packed bytes written over pending output");

endmodule

### bench/hcbp_checker.sv
// hcbp_checker: watches both streams of the code bit packer, predicts bytes, compares
// depends on hcbp_pkg for the kind codes and the code table entry layout
`timescale 1ns / 1ps

module hcbp_checker
  import hcbp_pkg::*;
#(
  parameter int unsigned MAX_CODE_LEN = 16
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_tvalid_i,
  input  logic        s_tready_i,
  input  logic [31:0] s_tdata_i,   // symbol[7:0], code_word[23:8], code_length[28:24]
  input  logic [0:0]  s_tuser_i,   // kind[0]
  input  logic        m_tvalid_i,
  input  logic        m_tready_i,
  input  logic [7:0]  m_tdata_i,   // out_byte[7:0]
  input  logic        m_tlast_i,
  output int unsigned mismatch_count_o,
  output int unsigned backlog_o
);

  typedef struct packed {
    logic [7:0] octet;
    logic       last;
  } packed_byte_t;

  code_entry_t       code_table [256] = '{default: '0};
  logic [PEND_W-1:0] pend_bits = '0;
  logic [CNT_W-1:0]  pend_cnt  = '0;
  packed_byte_t      expected_bytes [$];
  int unsigned       mismatches = 0;

  function automatic void note_mismatch(input string msg);
    mismatches++;
    if (mismatches <= 10) $display("%0t: %s", $time, msg);
  endfunction

  function automatic void load_entry(input logic [7:0] sym, input logic [WORD_BITS-1:0] word,
                                     input logic [LEN_W-1:0] len);
    int unsigned i;
    logic [WORD_BITS-1:0] kept;
    if (len >= 1 && len <= MAX_CODE_LEN && len <= WORD_BITS) begin
      kept = '0;
      for (i = 0; i < len; i++) kept[i] = word[i];
      code_table[sym].code = kept;
      code_table[sym].len  = len;
    end
  endfunction

  function automatic void pack_symbol(input logic [7:0] sym);
    code_entry_t       entry;
    int unsigned       n_bits;
    int unsigned       count;
    int unsigned       taken;
    int unsigned       i;
    logic [WORD_BITS-1:0] word;
    logic [ACC_W-1:0]  acc;
    packed_byte_t      pb;
    entry  = code_table[sym];
    n_bits = entry.len;
    if (n_bits > WORD_BITS) n_bits = 0;
    word = '0;
    for (i = 0; i < n_bits; i++) word[i] = entry.code[i];
    acc   = (ACC_W'(pend_bits) << n_bits) | ACC_W'(word);
    count = pend_cnt + n_bits;
    taken = 0;
    while (count >= BYTE_BITS && taken < 2) begin
      count    -= BYTE_BITS;
      pb.octet  = 8'(acc >> count);
      pb.last   = (count < BYTE_BITS) || (taken == 1);
      expected_bytes.push_back(pb);
      taken++;
    end
    pend_cnt  = CNT_W'(count);
    pend_bits = PEND_W'(acc & ((ACC_W'(1) << count) - ACC_W'(1)));
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    packed_byte_t want;
    int unsigned  k;
    if (!rst_ni) begin
      for (k = 0; k < 256; k++) code_table[k] = '0;
      pend_bits = '0;
      pend_cnt  = '0;
      expected_bytes.delete();
    end else begin
      if (m_tvalid_i && m_tready_i) begin
        if (expected_bytes.size() == 0) begin
          note_mismatch($sformatf("unexpected byte %02h last %0b", m_tdata_i, m_tlast_i));
        end else begin
          want = expected_bytes.pop_front();
          if (want.octet !== m_tdata_i || want.last !== m_tlast_i)
            note_mismatch($sformatf("byte expected %02h last %0b, got %02h last %0b",
                                    want.octet, want.last, m_tdata_i, m_tlast_i));
        end
      end
      if (s_tvalid_i && s_tready_i) begin
        if (kind_e'(s_tuser_i) == KIND_LOAD)
          load_entry(s_tdata_i[7:0], s_tdata_i[23:8], s_tdata_i[28:24]);
        else
          pack_symbol(s_tdata_i[7:0]);
      end
    end
    mismatch_count_o <= mismatches;
    backlog_o        <= expected_bytes.size();
  end

endmodule

### bench/tb.sv
// tb: stimulus and verdict for huffman_code_bit_packer_core
// depends on hcbp_pkg, the core and hcbp_checker, which predicts and compares
`timescale 1ns / 1ps

module tb
  import hcbp_pkg::*;
();

  localparam int unsigned MAX_CODE_LEN   = 16;
  localparam int unsigned WATCHDOG_LIMIT = 2000;
  localparam int unsigned HOLD_CYCLES    = 300;
  localparam int unsigned DRAIN_CYCLES   = 16;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [31:0] s_axis_tdata = '0;
  logic [0:0]  s_axis_tuser = '0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [7:0]  m_axis_tdata;
  logic        m_axis_tlast;

  int unsigned mismatch_count;
  int unsigned backlog;
  int unsigned tx_idle_pct = 0;
  int unsigned rx_idle_pct = 0;
  int unsigned hold_token = 0;
  int unsigned stall_cycles = 0;
  logic [7:0]  loaded_syms [$];
  bit          is_loaded [256];

  huffman_code_bit_packer_core dut (
    .clk_i           (clk),
    .rst_ni          (rst_n),
    .s_axis_tvalid_i (s_axis_tvalid),
    .s_axis_tready_o (s_axis_tready),
    .s_axis_tdata_i  (s_axis_tdata),
    .s_axis_tuser_i  (s_axis_tuser),
    .m_axis_tvalid_o (m_axis_tvalid),
    .m_axis_tready_i (m_axis_tready),
    .m_axis_tdata_o  (m_axis_tdata),
    .m_axis_tlast_o  (m_axis_tlast)
  );

  hcbp_checker #(.MAX_CODE_LEN(MAX_CODE_LEN)) u_checker (
    .clk_i            (clk),
    .rst_ni           (rst_n),
    .s_tvalid_i       (s_axis_tvalid),
    .s_tready_i       (s_axis_tready),
    .s_tdata_i        (s_axis_tdata),
    .s_tuser_i        (s_axis_tuser),
    .m_tvalid_i       (m_axis_tvalid),
    .m_tready_i       (m_axis_tready),
    .m_tdata_i        (m_axis_tdata),
    .m_tlast_i        (m_axis_tlast),
    .mismatch_count_o (mismatch_count),
    .backlog_o        (backlog)
  );

  always #5 clk = ~clk;

  // receiver: random stalls, plus one long hold-off whenever hold_token moves
  initial begin
    int unsigned hold_left;
    int unsigned hold_seen;
    hold_left = 0;
    hold_seen = 0;
    forever begin
      @(posedge clk);
      if (hold_seen != hold_token) begin
        hold_seen = hold_token;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        m_axis_tready <= 1'b0;
      end else begin
        m_axis_tready <= ($urandom_range(99) >= rx_idle_pct);
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
      stall_cycles <= 0;
    end else if (stall_cycles + 1 >= WATCHDOG_LIMIT) begin
      $display("huffman_code_bit_packer_core: mismatch");
      $finish;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

  task automatic send_item(input kind_e kind, input logic [7:0] sym,
                           input logic [15:0] word, input logic [4:0] len);
    while ($urandom_range(99) < tx_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= kind;
    s_axis_tdata  <= {3'b000, len, word, sym};
    @(posedge clk);
    while (!s_axis_tready) @(posedge clk);
    if (kind == KIND_LOAD && len >= 1 && len <= MAX_CODE_LEN && !is_loaded[sym]) begin
      is_loaded[sym] = 1'b1;
      loaded_syms.push_back(sym);
    end
  endtask

  task automatic encode_loaded(input logic [7:0] sym);
    send_item(KIND_ENCODE, sym, 16'($urandom), 5'($urandom));
  endtask

  // mostly encodes of loaded symbols; loads keep rewriting the table
  task automatic random_traffic(input int unsigned n_items);
    int unsigned done;
    logic [4:0]  len;
    done = 0;
    while (done < n_items) begin
      if (loaded_syms.size() == 0 || $urandom_range(99) < 25) begin
        len = ($urandom_range(9) == 0) ? 5'($urandom) : 5'($urandom_range(MAX_CODE_LEN, 1));
        send_item(KIND_LOAD, 8'($urandom), 16'($urandom), len);
        if (len >= 1 && len <= MAX_CODE_LEN) done++;
      end else begin
        encode_loaded(loaded_syms[$urandom_range(loaded_syms.size() - 1)]);
        done++;
      end
    end
  endtask

  initial begin
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: extreme codes, dropped upper bits, rejected lengths, byte straddling
    rx_idle_pct = 30;
    send_item(KIND_LOAD, 8'd0, 16'hFFFF, 5'd1);
    send_item(KIND_LOAD, 8'd255, 16'hA5C3, 5'd16);
    send_item(KIND_LOAD, 8'd1, 16'h00F0, 5'd0);
    send_item(KIND_LOAD, 8'd1, 16'h1234, 5'd17);
    send_item(KIND_LOAD, 8'd2, 16'hFFFF, 5'd31);
    send_item(KIND_LOAD, 8'd1, 16'h0F0F, 5'd8);
    send_item(KIND_LOAD, 8'd3, 16'h0000, 5'd7);
    send_item(KIND_LOAD, 8'd4, 16'h002A, 5'd6);
    encode_loaded(8'd255);
    repeat (7) encode_loaded(8'd0);
    encode_loaded(8'd0);
    encode_loaded(8'd3);
    encode_loaded(8'd255);
    encode_loaded(8'd1);
    send_item(KIND_LOAD, 8'd0, 16'h0000, 5'd16);
    send_item(KIND_LOAD, 8'd0, 16'h1234, 5'd0);
    encode_loaded(8'd0);
    encode_loaded(8'd4);
    send_item(KIND_ENCODE, 8'd1, 16'hFFFF, 5'd31);

    tx_idle_pct = 28;
    rx_idle_pct = 64;
    random_traffic(270);

    tx_idle_pct = 64;
    rx_idle_pct = 28;
    random_traffic(270);

    // no idling; the receiver holds off first so the core backs up
    tx_idle_pct = 0;
    rx_idle_pct = 0;
    hold_token++;
    random_traffic(260);

    s_axis_tvalid <= 1'b0;
    @(posedge clk);
    while (backlog != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatch_count == 0)
      $display("huffman_code_bit_packer_core: match");
    else
      $display("huffman_code_bit_packer_core: mismatch");
    $finish;
  end

endmodule
